// ===== design/tdga_pkg.sv =====
// Package for the trend-driven gain adapter: payload and command types,
// register indexes, fixed widths and rule constants.
// No dependencies; tdga_ctrl, tdga_dp and the top level import it.
`default_nettype none

package tdga_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int NUM_CH     = 4;
    localparam int GAIN_W     = 24;
    localparam int CUR_W      = 16;
    localparam int RATE_W     = 16;
    localparam int SLOPE_W    = 20;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    // Accumulator and arithmetic widths, sized for windows of up to 256 samples.
    localparam int SX_W      = 16;
    localparam int SXX_W     = 24;
    localparam int SY_W      = 24;
    localparam int SXY_W     = 32;
    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = 50;
    localparam int DEN_W     = 32;
    localparam int DIVD_W    = 42;
    localparam int REM_W     = 34;
    localparam int DIV_CNT_W = 6;
    localparam int PRODL_W   = GAIN_W + RATE_W;

    localparam int MIN_FILL   = 3;
    localparam int STEP_SHIFT = 18;

    localparam logic [CFG_IDX_W-1:0] REG_ADAPT_RATE = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LR     = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LR     = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_EX     = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_EX     = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_LR    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_EX    = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_CUR   = 4'd7;

    localparam logic [RATE_W-1:0] RST_ADAPT_RATE = 16'd3277;
    localparam logic [GAIN_W-1:0] RST_MIN_LR     = 24'd7;
    localparam logic [GAIN_W-1:0] RST_MAX_LR     = 24'd6554;
    localparam logic [GAIN_W-1:0] RST_MIN_EX     = 24'd655;
    localparam logic [GAIN_W-1:0] RST_MAX_EX     = 24'd65536;
    localparam logic [GAIN_W-1:0] RST_INIT_LR    = 24'd655;
    localparam logic [GAIN_W-1:0] RST_INIT_EX    = 24'd6554;
    localparam logic [CUR_W-1:0]  RST_INIT_CUR   = 16'd32768;

    localparam logic [1:0] CH_REWARD      = 2'd0;
    localparam logic [1:0] CH_COMPRESSION = 2'd1;
    localparam logic [1:0] CH_NOVELTY     = 2'd2;
    localparam logic [1:0] CH_ERROR       = 2'd3;

    localparam logic signed [SLOPE_W-1:0] SLOPE_MAX      = 20'sh7FFFF;
    localparam logic signed [SLOPE_W-1:0] SLOPE_MIN      = 20'sh80000;
    localparam logic signed [SLOPE_W-1:0] THR_HUNDREDTH  = 20'sd41;
    localparam logic signed [SLOPE_W-1:0] THR_THOUSANDTH = 20'sd4;

    localparam logic [CUR_W-1:0]   CUR_HI      = 16'd52429;
    localparam logic [CUR_W-1:0]   CUR_LO      = 16'd6554;
    localparam logic [GAIN_W-1:0]  GAIN_MAX    = 24'hFFFFFF;
    localparam logic [PRODL_W:0]   ROUND_16    = 41'h8000;
    localparam logic [PRODL_W:0]   ROUND_17    = 41'h10000;
    localparam logic [32:0]        STEP_RECIP  = 33'd52429;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] reward_sample;
        logic signed [SAMPLE_W-1:0] compression_sample;
        logic signed [SAMPLE_W-1:0] novelty_sample;
        logic signed [SAMPLE_W-1:0] error_sample;
    } tdga_in_t;

    typedef struct packed {
        logic [GAIN_W-1:0]         learning_rate_out;
        logic [GAIN_W-1:0]         exploration_out;
        logic [CUR_W-1:0]          curiosity_out;
        logic signed [SLOPE_W-1:0] reward_slope;
        logic signed [SLOPE_W-1:0] compression_slope;
        logic                      adapted;
    } tdga_out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_WALK,
        OP_MUL_NSXX,
        OP_MUL_SXSX,
        OP_DEN,
        OP_MUL_NSXY,
        OP_MUL_SXSY,
        OP_NUM,
        OP_DIV,
        OP_SLOPE,
        OP_LR_MUL,
        OP_LR_UPD,
        OP_EX_MUL,
        OP_EX_UPD,
        OP_FINISH
    } tdga_op_t;

    typedef struct packed {
        tdga_op_t   op;
        logic [1:0] ch;
    } tdga_cmd_t;

    typedef struct packed {
        logic short_window;
        logic walk_done;
        logic div_done;
        logic out_free;
    } tdga_status_t;

endpackage

`default_nettype wire

// ===== design/tdga_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module tdga_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  wire                       clk,
    input  wire                       we,
    input  wire  [$clog2(DEPTH)-1:0]  waddr,
    input  wire  [WIDTH-1:0]          wdata,
    input  wire  [$clog2(DEPTH)-1:0]  raddr,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/tdga_ctrl.sv =====
// Sequencer of the gain adapter: walks the datapath through window
// accumulation, slope division per channel and the gain updates.
// Depends on tdga_pkg.
`default_nettype none

module tdga_ctrl
    import tdga_pkg::*;
(
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_valid,
    output logic         s_ready,
    input  tdga_status_t status,
    output tdga_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_WALK, ST_NSXX, ST_SXSX, ST_DEN, ST_NSXY, ST_SXSY,
        ST_NUM, ST_DIV, ST_SLOPE, ST_LR_MUL, ST_LR_UPD, ST_EX_MUL, ST_EX_UPD, ST_FINISH
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] ch_reg, ch_next;
    logic       ready_reg;

    assign s_ready = ready_reg;

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        cmd.op     = OP_NONE;
        cmd.ch     = ch_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && ready_reg) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.short_window) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.op     = OP_WALK;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                cmd.op = OP_WALK;
                if (status.walk_done) begin
                    state_next = ST_NSXX;
                end
            end
            ST_NSXX: begin
                cmd.op     = OP_MUL_NSXX;
                state_next = ST_SXSX;
            end
            ST_SXSX: begin
                cmd.op     = OP_MUL_SXSX;
                state_next = ST_DEN;
            end
            ST_DEN: begin
                cmd.op     = OP_DEN;
                ch_next    = CH_REWARD;
                state_next = ST_NSXY;
            end
            ST_NSXY: begin
                cmd.op     = OP_MUL_NSXY;
                state_next = ST_SXSY;
            end
            ST_SXSY: begin
                cmd.op     = OP_MUL_SXSY;
                state_next = ST_NUM;
            end
            ST_NUM: begin
                cmd.op     = OP_NUM;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.op = OP_DIV;
                if (status.div_done) begin
                    state_next = ST_SLOPE;
                end
            end
            ST_SLOPE: begin
                cmd.op = OP_SLOPE;
                if (ch_reg == CH_ERROR) begin
                    state_next = ST_LR_MUL;
                end else begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = ST_NSXY;
                end
            end
            ST_LR_MUL: begin
                cmd.op     = OP_LR_MUL;
                state_next = ST_LR_UPD;
            end
            ST_LR_UPD: begin
                cmd.op     = OP_LR_UPD;
                state_next = ST_EX_MUL;
            end
            ST_EX_MUL: begin
                cmd.op     = OP_EX_MUL;
                state_next = ST_EX_UPD;
            end
            ST_EX_UPD: begin
                cmd.op     = OP_EX_UPD;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.op     = OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= CH_REWARD;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

`default_nettype wire

// ===== design/tdga_dp.sv =====
// Datapath of the gain adapter: configuration registers, sample window,
// sums, shared multiplier, slope divider, gain update and result register.
// Depends on tdga_pkg and tdga_ram.
`default_nettype none

module tdga_dp
    import tdga_pkg::*;
#(
    parameter int WINDOW = 16
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  tdga_cmd_t             cmd,
    output tdga_status_t          status,
    input  tdga_in_t              s_data,
    input  wire                   cfg_valid,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0] cfg_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output tdga_out_t             m_data
);

    localparam int PTR_W = $clog2(WINDOW);
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [CNT_W:0]     WIN_EXT    = (CNT_W + 1)'(WINDOW);
    localparam logic [PTR_W-1:0]   LAST_SLOT  = PTR_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0]   FULL_FILL  = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0]   MIN_FILL_C = CNT_W'(MIN_FILL);
    localparam logic [DIVD_W-1:0]  Q_POS_LIM  = DIVD_W'(524287);
    localparam logic [DIVD_W-1:0]  Q_NEG_LIM  = DIVD_W'(524288);

    // Configuration registers.
    logic [RATE_W-1:0] rate_reg;
    logic [GAIN_W-1:0] min_lr_reg, max_lr_reg, min_ex_reg, max_ex_reg;
    logic [GAIN_W-1:0] init_lr_reg, init_ex_reg;
    logic [CUR_W-1:0]  init_cur_reg;
    logic [CUR_W-1:0]  step_reg;

    // Window bookkeeping.
    logic [PTR_W-1:0] head_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] wi_reg;
    logic             rd_pend_reg;
    logic [PTR_W-1:0] rd_i_reg;

    // Sums.
    logic [SX_W-1:0]          sx_reg;
    logic [SXX_W-1:0]         sxx_reg;
    logic signed [SY_W-1:0]   sy_reg  [NUM_CH];
    logic signed [SXY_W-1:0]  sxy_reg [NUM_CH];

    // Arithmetic.
    logic signed [PROD_W-1:0]  prod_reg, t_reg;
    logic [DEN_W-1:0]          den_reg;
    logic [DIVD_W-1:0]         divd_reg;
    logic [REM_W-1:0]          rem_reg;
    logic [DIV_CNT_W-1:0]      div_cnt_reg;
    logic                      neg_reg;
    logic signed [SLOPE_W-1:0] slope_reg [NUM_CH];
    logic [NUM_CH-1:0]         pos_reg, numneg_reg;

    // Gains and result.
    logic [GAIN_W-1:0] lr_reg, ex_reg;
    logic [CUR_W-1:0]  cur_reg;
    tdga_out_t         out_reg;
    logic              out_valid_reg;

    // Configuration write decode; any valid index reloads the gains.
    logic              cfg_hit;
    logic [GAIN_W-1:0] init_lr_next, init_ex_next;
    logic [CUR_W-1:0]  init_cur_next;

    always_comb begin
        cfg_hit       = 1'b0;
        init_lr_next  = init_lr_reg;
        init_ex_next  = init_ex_reg;
        init_cur_next = init_cur_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_ADAPT_RATE, REG_MIN_LR, REG_MAX_LR, REG_MIN_EX, REG_MAX_EX: begin
                    cfg_hit = 1'b1;
                end
                REG_INIT_LR: begin
                    cfg_hit      = 1'b1;
                    init_lr_next = cfg_data;
                end
                REG_INIT_EX: begin
                    cfg_hit      = 1'b1;
                    init_ex_next = cfg_data;
                end
                REG_INIT_CUR: begin
                    cfg_hit       = 1'b1;
                    init_cur_next = cfg_data[CUR_W-1:0];
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Curiosity step round(a / 5) as a reciprocal multiply.
    logic [32:0] step_prod;
    assign step_prod = 33'({1'b0, rate_reg} + 17'd2) * STEP_RECIP;

    // Read address: oldest held slot plus the walk index, modulo the window.
    logic [CNT_W:0]   oldest_sum, oldest_ext, addr_sum, addr_ext;
    logic [PTR_W-1:0] rd_addr;
    logic             walk_go;

    always_comb begin
        oldest_sum = {1'b0, CNT_W'(head_reg)} + WIN_EXT - {1'b0, fill_reg};
        oldest_ext = (oldest_sum >= WIN_EXT) ? oldest_sum - WIN_EXT : oldest_sum;
        addr_sum   = oldest_ext + {1'b0, wi_reg};
        addr_ext   = (addr_sum >= WIN_EXT) ? addr_sum - WIN_EXT : addr_sum;
        rd_addr    = addr_ext[PTR_W-1:0];
    end

    assign walk_go = (cmd.op == OP_WALK) && (wi_reg != fill_reg);

    logic [$bits(tdga_in_t)-1:0] ram_rdata;

    tdga_ram #(
        .WIDTH ($bits(tdga_in_t)),
        .DEPTH (WINDOW)
    ) u_window (
        .clk   (aclk),
        .we    (cmd.op == OP_LOAD),
        .waddr (head_reg),
        .wdata (s_data),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    // Per-sample terms for the sums.
    logic signed [SAMPLE_W-1:0] rd_sample [NUM_CH];
    logic signed [SXY_W-1:0]    xy_term   [NUM_CH];
    logic signed [SXY_W-1:0]    ix_ext;
    logic [SXX_W-1:0]           ii_term;

    always_comb begin
        ix_ext  = SXY_W'(rd_i_reg);
        ii_term = SXX_W'(rd_i_reg) * SXX_W'(rd_i_reg);
        for (int c = 0; c < NUM_CH; c++) begin
            rd_sample[c] = ram_rdata[SAMPLE_W*(NUM_CH-c)-1 -: SAMPLE_W];
            xy_term[c]   = ix_ext * SXY_W'(rd_sample[c]);
        end
    end

    // Shared multiplier.
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_MUL_NSXX: begin
                mul_a = MUL_A_W'(sxx_reg);
                mul_b = MUL_B_W'(fill_reg);
            end
            OP_MUL_SXSX: begin
                mul_a = MUL_A_W'(sx_reg);
                mul_b = MUL_B_W'(sx_reg);
            end
            OP_MUL_NSXY: begin
                mul_a = MUL_A_W'(sxy_reg[cmd.ch]);
                mul_b = MUL_B_W'(fill_reg);
            end
            OP_MUL_SXSY: begin
                mul_a = MUL_A_W'(sy_reg[cmd.ch]);
                mul_b = MUL_B_W'(sx_reg);
            end
            OP_LR_MUL: begin
                mul_a = MUL_A_W'(lr_reg);
                mul_b = MUL_B_W'(rate_reg);
            end
            OP_EX_MUL: begin
                mul_a = MUL_A_W'(ex_reg);
                mul_b = MUL_B_W'(rate_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);
    end

    // Numerator magnitude and divider seed: quotient of (2|num| + den) / 2den.
    logic signed [PROD_W-1:0] num_full, num_mag;
    logic                     num_neg;
    logic [DIVD_W-1:0]        divd_init;

    always_comb begin
        num_full  = t_reg - prod_reg;
        num_neg   = num_full[PROD_W-1];
        num_mag   = num_neg ? -num_full : num_full;
        divd_init = {num_mag[DIVD_W-2:0], 1'b0} + DIVD_W'(den_reg);
    end

    // One restoring-division step per cycle.
    logic [REM_W-1:0] rem_shift, divisor_ext;
    logic             div_geq;

    always_comb begin
        rem_shift   = {rem_reg[REM_W-2:0], divd_reg[DIVD_W-1]};
        divisor_ext = REM_W'({den_reg, 1'b0});
        div_geq     = rem_shift >= divisor_ext;
    end

    logic signed [SLOPE_W-1:0] slope_val;

    always_comb begin
        if (neg_reg) begin
            slope_val = (divd_reg > Q_NEG_LIM) ? SLOPE_MIN
                                               : SLOPE_W'(0) - divd_reg[SLOPE_W-1:0];
        end else begin
            slope_val = (divd_reg > Q_POS_LIM) ? SLOPE_MAX : divd_reg[SLOPE_W-1:0];
        end
    end

    function automatic logic [GAIN_W-1:0] grow_gain(
        input logic [GAIN_W-1:0]  v,
        input logic [PRODL_W-1:0] p
    );
        logic [PRODL_W:0]  rnd;
        logic [GAIN_W+1:0] sum;
        rnd = {1'b0, p} + ROUND_16;
        sum = (GAIN_W + 2)'(v) + (GAIN_W + 2)'(rnd >> 16);
        return (sum > (GAIN_W + 2)'(GAIN_MAX)) ? GAIN_MAX : sum[GAIN_W-1:0];
    endfunction

    function automatic logic [GAIN_W-1:0] shrink_gain(
        input logic [GAIN_W-1:0]  v,
        input logic [PRODL_W-1:0] p,
        input logic               half
    );
        logic [PRODL_W:0] d;
        d = half ? (({1'b0, p} + ROUND_17) >> 17) : (({1'b0, p} + ROUND_16) >> 16);
        return (d > (PRODL_W + 1)'(v)) ? '0 : v - d[GAIN_W-1:0];
    endfunction

    function automatic logic [GAIN_W-1:0] clamp_gain(
        input logic [GAIN_W-1:0] v,
        input logic [GAIN_W-1:0] lo,
        input logic [GAIN_W-1:0] hi
    );
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Gain rules.
    logic [PRODL_W-1:0] prod_low;
    logic [GAIN_W-1:0]  lr_new, ex_new;
    logic               lr_up, lr_dn, ex_up, ex_dn, cur_up, cur_dn, adapted;
    logic [CUR_W:0]     cur_sum, cur_floor;
    logic [CUR_W-1:0]   cur_new;

    always_comb begin
        prod_low = prod_reg[PRODL_W-1:0];
        lr_up    = pos_reg[CH_ERROR];
        lr_dn    = numneg_reg[CH_REWARD] && (slope_reg[CH_ERROR] < -THR_HUNDREDTH);
        ex_up    = slope_reg[CH_NOVELTY] < -THR_THOUSANDTH;
        ex_dn    = (slope_reg[CH_NOVELTY] > THR_HUNDREDTH) && numneg_reg[CH_REWARD];
        cur_up   = slope_reg[CH_COMPRESSION] > THR_THOUSANDTH;
        cur_dn   = (slope_reg[CH_COMPRESSION] < -THR_THOUSANDTH) && numneg_reg[CH_REWARD];
        adapted  = fill_reg >= MIN_FILL_C;

        lr_new = lr_up ? grow_gain(lr_reg, prod_low)
               : (lr_dn ? shrink_gain(lr_reg, prod_low, 1'b1) : lr_reg);
        ex_new = ex_up ? grow_gain(ex_reg, prod_low)
               : (ex_dn ? shrink_gain(ex_reg, prod_low, 1'b0) : ex_reg);

        cur_sum   = {1'b0, cur_reg} + {1'b0, step_reg};
        cur_floor = {1'b0, step_reg} + {1'b0, CUR_LO};
        cur_new   = cur_reg;
        if (adapted) begin
            if (cur_up) begin
                cur_new = (cur_sum > {1'b0, CUR_HI}) ? CUR_HI : cur_sum[CUR_W-1:0];
            end else if (cur_dn) begin
                cur_new = ({1'b0, cur_reg} < cur_floor) ? CUR_LO : cur_reg - step_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rate_reg      <= RST_ADAPT_RATE;
            min_lr_reg    <= RST_MIN_LR;
            max_lr_reg    <= RST_MAX_LR;
            min_ex_reg    <= RST_MIN_EX;
            max_ex_reg    <= RST_MAX_EX;
            init_lr_reg   <= RST_INIT_LR;
            init_ex_reg   <= RST_INIT_EX;
            init_cur_reg  <= RST_INIT_CUR;
            lr_reg        <= RST_INIT_LR;
            ex_reg        <= RST_INIT_EX;
            cur_reg       <= RST_INIT_CUR;
            head_reg      <= '0;
            fill_reg      <= '0;
            wi_reg        <= '0;
            rd_pend_reg   <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_ADAPT_RATE: rate_reg   <= cfg_data[RATE_W-1:0];
                    REG_MIN_LR:     min_lr_reg <= cfg_data;
                    REG_MAX_LR:     max_lr_reg <= cfg_data;
                    REG_MIN_EX:     min_ex_reg <= cfg_data;
                    REG_MAX_EX:     max_ex_reg <= cfg_data;
                    default: begin
                    end
                endcase
            end
            init_lr_reg  <= init_lr_next;
            init_ex_reg  <= init_ex_next;
            init_cur_reg <= init_cur_next;

            if (cfg_hit) begin
                lr_reg  <= init_lr_next;
                ex_reg  <= init_ex_next;
                cur_reg <= init_cur_next;
            end else begin
                case (cmd.op)
                    OP_LR_UPD: lr_reg  <= clamp_gain(lr_new, min_lr_reg, max_lr_reg);
                    OP_EX_UPD: ex_reg  <= clamp_gain(ex_new, min_ex_reg, max_ex_reg);
                    OP_FINISH: cur_reg <= cur_new;
                    default: begin
                    end
                endcase
            end

            if (cmd.op == OP_LOAD) begin
                head_reg <= (head_reg == LAST_SLOT) ? '0 : head_reg + PTR_W'(1);
                fill_reg <= (fill_reg == FULL_FILL) ? fill_reg : fill_reg + CNT_W'(1);
                wi_reg   <= '0;
            end else if (walk_go) begin
                wi_reg <= wi_reg + CNT_W'(1);
            end
            rd_pend_reg <= walk_go;

            if (cmd.op == OP_NUM) begin
                div_cnt_reg <= '0;
            end else if (cmd.op == OP_DIV && !status.div_done) begin
                div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
            end

            if (cmd.op == OP_FINISH) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        step_reg <= step_prod[STEP_SHIFT +: CUR_W];
        if (walk_go) begin
            rd_i_reg <= wi_reg[PTR_W-1:0];
        end

        if (cmd.op == OP_LOAD) begin
            sx_reg  <= '0;
            sxx_reg <= '0;
            for (int c = 0; c < NUM_CH; c++) begin
                sy_reg[c]  <= '0;
                sxy_reg[c] <= '0;
            end
        end else if (rd_pend_reg) begin
            sx_reg  <= sx_reg + SX_W'(rd_i_reg);
            sxx_reg <= sxx_reg + ii_term;
            for (int c = 0; c < NUM_CH; c++) begin
                sy_reg[c]  <= sy_reg[c] + SY_W'(rd_sample[c]);
                sxy_reg[c] <= sxy_reg[c] + xy_term[c];
            end
        end

        case (cmd.op)
            OP_MUL_NSXX, OP_MUL_NSXY, OP_LR_MUL, OP_EX_MUL: begin
                prod_reg <= mul_p;
            end
            OP_MUL_SXSX, OP_MUL_SXSY: begin
                t_reg    <= prod_reg;
                prod_reg <= mul_p;
            end
            OP_DEN: begin
                den_reg <= num_full[DEN_W-1:0];
            end
            OP_NUM: begin
                divd_reg           <= divd_init;
                rem_reg            <= '0;
                neg_reg            <= num_neg;
                pos_reg[cmd.ch]    <= !num_neg && (num_full != '0);
                numneg_reg[cmd.ch] <= num_neg;
            end
            OP_DIV: begin
                if (!status.div_done) begin
                    rem_reg  <= div_geq ? rem_shift - divisor_ext : rem_shift;
                    divd_reg <= {divd_reg[DIVD_W-2:0], div_geq};
                end
            end
            OP_SLOPE: begin
                slope_reg[cmd.ch] <= slope_val;
            end
            OP_FINISH: begin
                out_reg.learning_rate_out <= lr_reg;
                out_reg.exploration_out   <= ex_reg;
                out_reg.curiosity_out     <= cur_new;
                out_reg.reward_slope      <= adapted ? slope_reg[CH_REWARD] : '0;
                out_reg.compression_slope <= adapted ? slope_reg[CH_COMPRESSION] : '0;
                out_reg.adapted           <= adapted;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        status.short_window = fill_reg < MIN_FILL_C;
        status.walk_done    = (wi_reg == fill_reg) && !rd_pend_reg;
        status.div_done     = div_cnt_reg == DIV_CNT_W'(DIVD_W);
        status.out_free     = !out_valid_reg || m_ready;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== design/trend_driven_gain_adapter.sv =====
// Trend-driven gain adapter, top level.
//
// Each request on the s_ channel carries one sample of four channels (reward,
// compression progress, novelty, prediction error), each signed Q4.12. The
// block stores it in a window of the last WINDOW samples. With three or more
// samples held, it walks the window once to build the least-squares sums,
// then computes four slopes one after the other with a bit-serial divider,
// and updates learning rate, exploration and curiosity from them. Each
// request yields exactly one result request on the m_ channel.
// With fewer than three samples held, the block goes straight to loading the
// output register; otherwise it walks the window, forms the denominator, runs
// each channel through the one-bit-per-cycle divider, then performs the gain
// updates and loads the output register. One request is processed at a time;
// s_ready returns as soon as the result sits in the output register.
// A stalled receiver holds that result; a following request then waits in
// its final step until the output register frees up.
// The cfg_ channel is always ready; writing any valid register index also
// reloads the three gains from their initial registers. Reset (aresetn,
// synchronous, active low) restores register defaults, empties the window
// and loads the initial gains. No clearing pass is needed.
`default_nettype none

module trend_driven_gain_adapter
    import tdga_pkg::*;
#(
    parameter int WINDOW = 16
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   s_valid,
    output logic                  s_ready,
    input  tdga_in_t              s_data,
    output logic                  m_valid,
    input  wire                   m_ready,
    output tdga_out_t             m_data,
    input  wire                   cfg_valid,
    output logic                  cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  cfg_index,
    input  wire  [CFG_DATA_W-1:0] cfg_data
);

    tdga_cmd_t    cmd;
    tdga_status_t status;

    // Configuration writes must only arrive while the block is idle; the block
    // itself does not enforce this, and they are always taken.
    assign cfg_ready = 1'b1;

    tdga_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tdga_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // An accepted request keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready
    ) else $error("input accepted while previous request in progress");

    // A result without adaptation reports zero slopes.
    a_short_zero_slopes: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.adapted |->
            (m_data.reward_slope == '0) && (m_data.compression_slope == '0)
    ) else $error("non-adapted result carries a slope");

    // The result register is only loaded when it is free.
    a_finish_free: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (cmd.op == OP_FINISH) |-> status.out_free
    ) else $error("result overwritten while still pending");

endmodule

`default_nettype wire

// ===== test/tb_trend_driven_gain_adapter.sv =====
// Self-checking testbench for trend_driven_gain_adapter: drives sample
// requests and register writes, predicts every result and compares it.
// Depends on design/tdga_pkg.sv and design/trend_driven_gain_adapter.sv.
`timescale 1ns / 1ps

module tb_trend_driven_gain_adapter;
    import tdga_pkg::*;

    localparam int WIN        = 16;
    localparam int IDLE_LIMIT = 6000;
    localparam int SETTLE     = 300;
    localparam int NUM_PHASES = 9;
    localparam int PHASE_LEN  = 140;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    tdga_in_t              s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    tdga_out_t             m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    trend_driven_gain_adapter #(.WINDOW(WIN)) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Sample requests waiting to be sent, and results waiting to arrive.
    tdga_in_t  pending_samples[$];
    tdga_out_t expected_results[$];

    // Shadow copy of the block's registers and state.
    logic [23:0]        shadow_regs[8];
    logic signed [15:0] sample_hist[WIN][4];
    int unsigned        hist_head;
    int unsigned        hist_fill;
    logic [23:0]        lr_now;
    logic [23:0]        ex_now;
    logic [15:0]        cur_now;

    int  mismatches = 0;
    int  results_seen = 0;
    int  adapted_seen = 0;
    int  cfg_writes = 0;
    int  s_gap = 0;
    int  m_stall = 0;
    int  m_draw = 0;
    int  idle_cycles = 0;
    bit  no_idle = 1'b0;

    // Exact least-squares slope over the held samples of one channel,
    // rounded to nearest with ties away from zero and saturated to 20 bits.
    // The sign of the unrounded numerator is returned separately, because the
    // zero tests of the rules look at it rather than at the rounded slope.
    function automatic int trend_slope(int ch, int n, output int num_sign);
        longint sx, sy, sxy, sxx, y, num, den, mag, q;
        int unsigned oldest;
        sx = 0; sy = 0; sxy = 0; sxx = 0;
        oldest = (hist_head + WIN - n) % WIN;
        for (int i = 0; i < n; i++) begin
            y = sample_hist[(oldest + i) % WIN][ch];
            sx += i;
            sy += y;
            sxy += i * y;
            sxx += i * i;
        end
        num = n * sxy - sx * sy;
        den = n * sxx - sx * sx;
        num_sign = (num > 0) ? 1 : ((num < 0) ? -1 : 0);
        if (den <= 0) return 0;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        if (num < 0) return (q > 524288) ? -524288 : -int'(q);
        return (q > 524287) ? 524287 : int'(q);
    endfunction

    function automatic logic [23:0] scaled_up(logic [23:0] v, logic [15:0] a);
        longint r;
        r = longint'(v) + ((longint'(v) * a + 32768) >>> 16);
        return (r > 24'hFFFFFF) ? 24'hFFFFFF : r[23:0];
    endfunction

    function automatic logic [23:0] scaled_down(logic [23:0] v, logic [15:0] a, int sh);
        longint d;
        d = (longint'(v) * a + (longint'(1) << (sh - 1))) >>> sh;
        return (d > v) ? 24'd0 : 24'(longint'(v) - d);
    endfunction

    function automatic logic [23:0] bound(logic [23:0] v, logic [23:0] lo, logic [23:0] hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void reload_gains();
        lr_now  = shadow_regs[REG_INIT_LR];
        ex_now  = shadow_regs[REG_INIT_EX];
        cur_now = shadow_regs[REG_INIT_CUR][15:0];
    endfunction

    // Advances the shadow state by one sample and returns the result it causes.
    function automatic tdga_out_t predict_gains(tdga_in_t smp);
        tdga_out_t res;
        int slope[4];
        int sgn[4];
        logic [15:0] rate;
        int step, cur;
        sample_hist[hist_head][CH_REWARD]      = smp.reward_sample;
        sample_hist[hist_head][CH_COMPRESSION] = smp.compression_sample;
        sample_hist[hist_head][CH_NOVELTY]     = smp.novelty_sample;
        sample_hist[hist_head][CH_ERROR]       = smp.error_sample;
        hist_head = (hist_head + 1) % WIN;
        if (hist_fill < WIN) hist_fill++;
        for (int c = 0; c < 4; c++) begin
            slope[c] = 0;
            sgn[c] = 0;
        end
        res.adapted = 1'b0;
        if (hist_fill >= 3) begin
            res.adapted = 1'b1;
            rate = shadow_regs[REG_ADAPT_RATE][15:0];
            for (int c = 0; c < 4; c++) slope[c] = trend_slope(c, hist_fill, sgn[c]);

            // Rising error speeds learning up; falling reward with clearly
            // falling error slows it down.
            if (sgn[CH_ERROR] > 0)
                lr_now = scaled_up(lr_now, rate);
            else if (sgn[CH_REWARD] < 0 && slope[CH_ERROR] < -41)
                lr_now = scaled_down(lr_now, rate, 17);
            lr_now = bound(lr_now, shadow_regs[REG_MIN_LR], shadow_regs[REG_MAX_LR]);

            // Fading novelty pushes exploration up; rising novelty under a
            // falling reward pulls it down.
            if (slope[CH_NOVELTY] < -4)
                ex_now = scaled_up(ex_now, rate);
            else if (slope[CH_NOVELTY] > 41 && sgn[CH_REWARD] < 0)
                ex_now = scaled_down(ex_now, rate, 16);
            ex_now = bound(ex_now, shadow_regs[REG_MIN_EX], shadow_regs[REG_MAX_EX]);

            step = (int'(rate) + 2) / 5;
            if (slope[CH_COMPRESSION] > 4) begin
                cur = int'(cur_now) + step;
                cur_now = (cur > int'(CUR_HI)) ? CUR_HI : 16'(cur);
            end else if (slope[CH_COMPRESSION] < -4 && sgn[CH_REWARD] < 0) begin
                cur = int'(cur_now) - step;
                cur_now = (cur < int'(CUR_LO)) ? CUR_LO : 16'(cur);
            end
        end
        res.learning_rate_out = lr_now;
        res.exploration_out   = ex_now;
        res.curiosity_out     = cur_now;
        res.reward_slope      = slope[CH_REWARD][19:0];
        res.compression_slope = slope[CH_COMPRESSION][19:0];
        return res;
    endfunction

    // Request driver: one request in flight, a random gap after each.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && s_ready) begin
            expected_results = {expected_results, predict_gains(s_data)};
            s_valid <= 1'b0;
            s_gap <= no_idle ? 0 : $urandom_range(0, 6);
        end else if (!s_valid) begin
            if (s_gap > 0) begin
                s_gap <= s_gap - 1;
            end else if (pending_samples.size() > 0) begin
                s_data <= pending_samples[0];
                pending_samples.delete(0);
                s_valid <= 1'b1;
            end
        end
    end

    // Result monitor: a random stall before taking each result.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            results_seen++;
            if (m_data.adapted) adapted_seen++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result %p", m_data);
            end else begin
                tdga_out_t want;
                want = expected_results[0];
                expected_results.delete(0);
                if (m_data.learning_rate_out !== want.learning_rate_out ||
                    m_data.exploration_out !== want.exploration_out ||
                    m_data.curiosity_out !== want.curiosity_out ||
                    m_data.reward_slope !== want.reward_slope ||
                    m_data.compression_slope !== want.compression_slope ||
                    m_data.adapted !== want.adapted) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: result %0d expected %p got %p",
                                 results_seen, want, m_data);
                end
            end
            m_draw = no_idle ? 0 : $urandom_range(0, 6);
            m_stall <= m_draw;
            m_ready <= (m_draw == 0);
        end else if (!m_ready) begin
            if (m_stall > 0) m_stall <= m_stall - 1;
            else m_ready <= 1'b1;
        end
    end

    // Register writes update the shadow copy when they are accepted; any
    // valid index reloads the gains, indexes past the last register do nothing.
    always @(posedge aclk) begin
        if (aresetn && cfg_valid && cfg_ready) begin
            if (cfg_index < 8) begin
                shadow_regs[cfg_index] = (cfg_index == REG_ADAPT_RATE ||
                                          cfg_index == REG_INIT_CUR) ?
                                         {8'd0, cfg_data[15:0]} : cfg_data;
                reload_gains();
            end
            cfg_writes++;
            cfg_valid <= 1'b0;
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("TIMEOUT: no progress for %0d cycles", IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic signed [15:0] clip16(int v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return v[15:0];
    endfunction

    task automatic add_sample(int r, int c, int nv, int e);
        tdga_in_t smp;
        smp.reward_sample      = clip16(r);
        smp.compression_sample = clip16(c);
        smp.novelty_sample     = clip16(nv);
        smp.error_sample       = clip16(e);
        pending_samples = {pending_samples, smp};
    endtask

    // A run of samples that follow a line per channel plus noise, so that the
    // slopes land on both sides of every threshold.
    task automatic add_trend(int len);
        int base[4], rise[4];
        int noise;
        int v[4];
        noise = $urandom_range(0, 1) ? 0 : $urandom_range(0, 3000);
        for (int c = 0; c < 4; c++) begin
            base[c] = $urandom_range(0, 65535) - 32768;
            case ($urandom_range(0, 3))
                0: rise[c] = 0;
                1: rise[c] = $urandom_range(0, 100) - 50;
                2: rise[c] = $urandom_range(0, 1000) - 500;
                default: rise[c] = $urandom_range(0, 8000) - 4000;
            endcase
        end
        for (int i = 0; i < len; i++) begin
            for (int c = 0; c < 4; c++)
                v[c] = base[c] + rise[c] * i + $urandom_range(0, 2 * noise) - noise;
            add_sample(v[0], v[1], v[2], v[3]);
        end
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (cfg_valid) @(posedge aclk);
    endtask

    // Waits until every request has gone and every result has come back, then
    // lets the block settle so that no register write lands mid-computation.
    task automatic drain();
        while (pending_samples.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    initial begin
        logic [23:0] vals[8];
        int order[8];
        int n_random;
        shadow_regs[REG_ADAPT_RATE] = RST_ADAPT_RATE;
        shadow_regs[REG_MIN_LR]     = RST_MIN_LR;
        shadow_regs[REG_MAX_LR]     = RST_MAX_LR;
        shadow_regs[REG_MIN_EX]     = RST_MIN_EX;
        shadow_regs[REG_MAX_EX]     = RST_MAX_EX;
        shadow_regs[REG_INIT_LR]    = RST_INIT_LR;
        shadow_regs[REG_INIT_EX]    = RST_INIT_EX;
        shadow_regs[REG_INIT_CUR]   = RST_INIT_CUR;
        hist_head = 0;
        hist_fill = 0;
        reload_gains();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part. The first two samples leave the window too short to
        // adapt; then flat, extreme and steep windows, every rule in both
        // directions, and enough samples to wrap the window.
        add_sample(0, 0, 0, 0);
        add_sample(32767, 32767, 32767, 32767);
        add_sample(-32768, -32768, -32768, -32768);
        add_sample(0, 0, 0, 0);
        for (int i = 0; i < 4; i++) add_sample(-8000 * i, -8000 * i, 8000 * i, -8000 * i);
        for (int i = 0; i < 4; i++) add_sample(8000 * i, 8000 * i, -8000 * i, 8000 * i);
        for (int i = 0; i < 6; i++)
            add_sample((i % 2) ? 32767 : -32768, (i % 2) ? -32768 : 32767,
                       (i % 2) ? 32767 : -32768, (i % 2) ? -32768 : 32767);
        for (int i = 0; i < 6; i++) add_sample(-i, i, -i, i);
        drain();

        // Random phases, each under its own register setting: the extremes, the
        // default bounds with a zero rate, crossed bounds and random values.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph % 5)
                0: vals = '{24'd65535, 24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF,
                            24'hFFFFF0, 24'd1, 24'(CUR_HI)};
                1: vals = '{24'd0, 24'd7, 24'd6554, 24'd655, 24'd65536,
                            24'd655, 24'd6554, 24'(CUR_LO)};
                2: vals = '{24'($urandom_range(0, 65535)), 24'd50000, 24'd100,
                            24'hFFFFFF, 24'd0, 24'($urandom_range(0, 200000)),
                            24'($urandom_range(0, 200000)), 24'd40000};
                3: vals = '{24'd65535, 24'd0, 24'd0, 24'hFFFFFF, 24'hFFFFFF,
                            24'd0, 24'hFFFFFF, 24'd6554};
                default: begin
                    vals[0] = 24'($urandom_range(0, 65535));
                    for (int k = 1; k < 7; k++)
                        vals[k] = 24'($urandom_range(0, 24'hFFFFFF));
                    vals[7] = 24'($urandom_range(CUR_LO, CUR_HI));
                end
            endcase
            // Writes go in a random order of indexes, each with its own value;
            // a write to an unused index follows and must change nothing.
            for (int k = 0; k < 8; k++) order[k] = k;
            for (int k = 0; k < 8; k++) begin
                int j;
                int t;
                j = $urandom_range(k, 7);
                t = order[j]; order[j] = order[k]; order[k] = t;
                write_reg(CFG_IDX_W'(order[k]), vals[order[k]]);
            end
            write_reg(CFG_IDX_W'($urandom_range(8, 15)), 24'($urandom));

            no_idle = ($urandom_range(0, 3) == 0);
            n_random = 0;
            while (n_random < PHASE_LEN) begin
                if ($urandom_range(0, 4) == 0) begin
                    add_sample($urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                               $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768);
                    n_random++;
                end else begin
                    int len;
                    len = $urandom_range(3, 24);
                    add_trend(len);
                    n_random += len;
                end
            end
            drain();
        end

        $display("Covered %0d results (%0d adapted) over %0d register writes and %0d settings.",
                 results_seen, adapted_seen, cfg_writes, NUM_PHASES + 1);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("Mismatching results: %0d", mismatches);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/tdga_pkg.sv
design/tdga_ram.sv
design/tdga_ctrl.sv
design/tdga_dp.sv
design/trend_driven_gain_adapter.sv
test/tb_trend_driven_gain_adapter.sv
